@@ design/sha1md_pkg.sv @@
// Shared types, constants and round functions for the SHA-1 digest block.
// No dependencies; used by sha1md_core and sha1_message_digest.
package sha1md_pkg;

   localparam int HASH_WORDS = 5;

   typedef logic [31:0] word_type;
   typedef word_type [HASH_WORDS-1:0] hash_type;

   typedef enum logic [1:0] {
      PH_CHOOSE,
      PH_PARITY_LO,
      PH_MAJORITY,
      PH_PARITY_HI
   } phase_type;

   typedef struct packed {
      logic       init;
      logic       shift_byte;
      logic [7:0] byte_val;
      logic       start;
      logic       round;
      phase_type  phase;
      logic       fold;
   } core_ctrl_type;

   localparam hash_type INIT_HASH = '{
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [7:0] PAD_MARKER = 8'h80;

   function automatic word_type round_k(input phase_type ph);
      word_type k;
      unique case (ph)
         PH_CHOOSE:    k = 32'h5A827999;
         PH_PARITY_LO: k = 32'h6ED9EBA1;
         PH_MAJORITY:  k = 32'h8F1BBCDC;
         PH_PARITY_HI: k = 32'hCA62C1D6;
         default:      k = 32'h5A827999;
      endcase
      return k;
   endfunction

   function automatic word_type round_f(input phase_type ph, input word_type b,
                                        input word_type c, input word_type d);
      word_type f;
      unique case (ph)
         PH_CHOOSE:   f = (b & c) | (~b & d);
         PH_MAJORITY: f = (b & c) | (b & d) | (c & d);
         default:     f = b ^ c ^ d;
      endcase
      return f;
   endfunction

endpackage

@@ design/sha1md_core.sv @@
// SHA-1 compression datapath: 64-byte block shift line, one round per cycle,
// working variables and chaining words. Depends on sha1md_pkg.
module sha1md_core
   import sha1md_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  core_ctrl_type ctrl,
   output hash_type      hash_words
);

   logic [511:0] blk_ff;
   logic [511:0] blk_in;
   word_type     a_ff, b_ff, c_ff, d_ff, e_ff;
   hash_type     hash_ff;

   word_type w_cur;
   word_type w_mix;
   word_type w_new;
   word_type t_sum;

   assign w_cur = blk_ff[511:480];
   assign w_mix = blk_ff[95:64] ^ blk_ff[255:224] ^ blk_ff[447:416] ^ blk_ff[511:480];
   assign w_new = {w_mix[30:0], w_mix[31]};
   assign t_sum = {a_ff[26:0], a_ff[31:27]} + round_f(ctrl.phase, b_ff, c_ff, d_ff)
                  + e_ff + round_k(ctrl.phase) + w_cur;

   always_comb begin
      blk_in = blk_ff;
      if (ctrl.shift_byte) begin
         blk_in = {blk_ff[503:0], ctrl.byte_val};
      end else if (ctrl.round) begin
         blk_in = {blk_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      if (ctrl.start) begin
         a_ff <= hash_ff[0];
         b_ff <= hash_ff[1];
         c_ff <= hash_ff[2];
         d_ff <= hash_ff[3];
         e_ff <= hash_ff[4];
      end else if (ctrl.round) begin
         a_ff <= t_sum;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.init) begin
         hash_ff <= INIT_HASH;
      end else if (ctrl.fold) begin
         hash_ff[0] <= hash_ff[0] + a_ff;
         hash_ff[1] <= hash_ff[1] + b_ff;
         hash_ff[2] <= hash_ff[2] + c_ff;
         hash_ff[3] <= hash_ff[3] + d_ff;
         hash_ff[4] <= hash_ff[4] + e_ff;
      end
   end

   assign hash_words = hash_ff;

endmodule

@@ design/sha1_message_digest.sv @@
// Top level of the SHA-1 message digest: stream ports, padding and round sequencer.
// Depends on sha1md_pkg and sha1md_core.
//
//   Channel   Direction   Beat contents
//   req_      in          tdata: data_byte; tuser: has_byte; tlast: end_of_message
//   rsp_      out         tdata: digest_word; tlast: last_word
//
// A message byte that fills a block starts a compression: the 80 rounds of the shared round unit
// in ST_ROUNDS, then a fold into the chaining words in ST_FOLD; no bytes are taken meanwhile.
// An end beat shifts padding and length one byte per cycle up to the block end, runs one
// or two compressions, and then offers five digest beats.
// Reset is synchronous and restores the initial chaining words; no clearing pass is needed.
// req_tready is high only while idle; a stalled rsp_ beat holds until taken.
module sha1_message_digest
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic        rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_ROUNDS,
      ST_FOLD,
      ST_OUT
   } state_type;

   localparam logic [6:0]  LAST_ROUND    = 7'd79;
   localparam logic [6:0]  PHASE1_ROUND  = 7'd20;
   localparam logic [6:0]  PHASE2_ROUND  = 7'd40;
   localparam logic [6:0]  PHASE3_ROUND  = 7'd60;
   localparam logic [5:0]  BLOCK_END_POS = 6'd63;
   localparam logic [5:0]  PAD_END_POS   = 6'd55;
   localparam logic [2:0]  LAST_WORD_IDX = 3'(HASH_WORDS - 1);

   state_type     state_ff, state_in;
   logic [5:0]    pos_ff, pos_in;
   logic [60:0]   count_ff, count_in;
   logic [63:0]   len_ff, len_in;
   logic          fin_ff, fin_in;
   logic          final_ff, final_in;
   logic          marker_ff, marker_in;
   logic [6:0]    rnd_ff, rnd_in;
   logic [2:0]    idx_ff, idx_in;
   logic [60:0]   count_nx;
   core_ctrl_type ctrl;
   hash_type      hash_words;

   sha1md_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .hash_words (hash_words)
   );

   assign count_nx = count_ff + 61'(req_tuser);

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      fin_in    = fin_ff;
      final_in  = final_ff;
      marker_in = marker_ff;
      rnd_in    = rnd_ff;
      idx_in    = idx_ff;
      ctrl      = '0;
      ctrl.phase = PH_CHOOSE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pos_in = count_nx[5:0];
               if (req_tuser) begin
                  ctrl.shift_byte = 1'b1;
                  ctrl.byte_val   = req_tdata;
                  count_in        = count_nx;
               end
               if (req_tlast) begin
                  fin_in    = 1'b1;
                  len_in    = {count_nx, 3'b000};
                  marker_in = 1'b0;
               end
               if (req_tuser && count_ff[5:0] == BLOCK_END_POS) begin
                  state_in   = ST_ROUNDS;
                  ctrl.start = 1'b1;
                  rnd_in     = '0;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            ctrl.shift_byte = 1'b1;
            ctrl.byte_val   = marker_ff ? 8'h00 : PAD_MARKER;
            marker_in       = 1'b1;
            pos_in          = pos_ff + 6'd1;
            if (pos_ff == BLOCK_END_POS) begin
               state_in   = ST_ROUNDS;
               ctrl.start = 1'b1;
               rnd_in     = '0;
            end else if (pos_ff == PAD_END_POS) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            ctrl.shift_byte = 1'b1;
            ctrl.byte_val   = len_ff[63:56];
            len_in          = {len_ff[55:0], 8'h00};
            pos_in          = pos_ff + 6'd1;
            if (pos_ff == BLOCK_END_POS) begin
               state_in   = ST_ROUNDS;
               ctrl.start = 1'b1;
               rnd_in     = '0;
               final_in   = 1'b1;
            end
         end
         ST_ROUNDS: begin
            ctrl.round = 1'b1;
            priority if (rnd_ff < PHASE1_ROUND) begin
               ctrl.phase = PH_CHOOSE;
            end else if (rnd_ff < PHASE2_ROUND) begin
               ctrl.phase = PH_PARITY_LO;
            end else if (rnd_ff < PHASE3_ROUND) begin
               ctrl.phase = PH_MAJORITY;
            end else begin
               ctrl.phase = PH_PARITY_HI;
            end
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            ctrl.fold = 1'b1;
            priority if (final_ff) begin
               state_in = ST_OUT;
               idx_in   = '0;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               if (idx_ff == LAST_WORD_IDX) begin
                  ctrl.init = 1'b1;
                  count_in  = '0;
                  fin_in    = 1'b0;
                  final_in  = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         fin_ff    <= 1'b0;
         final_ff  <= 1'b0;
         marker_ff <= 1'b0;
         rnd_ff    <= '0;
         idx_ff    <= '0;
         pos_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         fin_ff    <= fin_in;
         final_ff  <= final_in;
         marker_ff <= marker_in;
         rnd_ff    <= rnd_in;
         idx_ff    <= idx_in;
         pos_ff    <= pos_in;
      end
      len_ff <= len_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = hash_words[idx_ff];
   assign rsp_tlast  = (idx_ff == LAST_WORD_IDX);

   // The input side is never open while a digest beat is offered.
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("input ready while digest beats pending");

   // The round counter never runs past the last round.
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_ROUNDS) |-> (rnd_ff <= LAST_ROUND))
      else $error("round counter out of range");

   // The final digest beat returns the block to idle at once.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block not idle after final digest beat");

   // Digest beats start only after the last block has been folded in.
   assert property (@(posedge clock) disable iff (reset)
                    $rose(rsp_tvalid) |-> $past(state_ff == ST_FOLD && final_ff))
      else $error("digest offered without a final fold");

endmodule

@@ tb/sv/sha1_digest_checker.sv @@
`timescale 1ns / 100ps
// Checker for sha1_message_digest: watches the req_ and rsp_ stream channels,
// predicts the SHA-1 digest of each message and compares every digest beat.
// Depends on sha1md_pkg for the word and hash types and the initial chaining words.
module sha1_digest_checker
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          words_pending
);

   typedef struct {
      word_type word;
      logic     last;
   } digest_beat_type;

   hash_type        chain;
   logic [7:0]      blk [64];
   logic [60:0]     msg_bytes;
   digest_beat_type digest_queue [$];

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      fail_count++;
   endtask

   function automatic void fold_block();
      word_type  sched [80];
      word_type  a, b, c, d, e, f, k, t, x;
      phase_type grp;
      for (int i = 0; i < 16; i++) begin
         sched[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      end
      for (int i = 16; i < 80; i++) begin
         x = sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16];
         sched[i] = {x[30:0], x[31]};
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int i = 0; i < 80; i++) begin
         grp = phase_type'(i / 20);
         case (grp)
            PH_CHOOSE: begin
               f = (b & c) | (~b & d);
               k = 32'h5A827999;
            end
            PH_PARITY_LO: begin
               f = b ^ c ^ d;
               k = 32'h6ED9EBA1;
            end
            PH_MAJORITY: begin
               f = (b & c) | (b & d) | (c & d);
               k = 32'h8F1BBCDC;
            end
            default: begin
               f = b ^ c ^ d;
               k = 32'hCA62C1D6;
            end
         endcase
         t = {a[26:0], a[31:27]} + f + e + k + sched[i];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
   endfunction

   function automatic void append_byte(input logic [7:0] value);
      logic [5:0] pos;
      pos = msg_bytes[5:0];
      blk[pos] = value;
      msg_bytes = msg_bytes + 61'd1;
      if (pos == 6'd63) begin
         fold_block();
      end
   endfunction

   function automatic void finish_message();
      logic [63:0]     bit_len;
      int              pos;
      digest_beat_type beat;
      bit_len = {msg_bytes, 3'b000};
      pos = int'(msg_bytes[5:0]);
      blk[pos] = PAD_MARKER;
      pos++;
      if (pos > 56) begin
         while (pos < 64) begin
            blk[pos] = 8'h00;
            pos++;
         end
         fold_block();
         pos = 0;
      end
      while (pos < 56) begin
         blk[pos] = 8'h00;
         pos++;
      end
      for (int i = 0; i < 8; i++) begin
         blk[56+i] = bit_len[63-8*i -: 8];
      end
      fold_block();
      for (int w = 0; w < HASH_WORDS; w++) begin
         beat.word = chain[w];
         beat.last = (w == HASH_WORDS - 1);
         digest_queue.push_back(beat);
      end
      chain = INIT_HASH;
      msg_bytes = '0;
   endfunction

   task automatic check_digest_beat(input word_type word, input logic last);
      digest_beat_type want;
      if (digest_queue.size() == 0) begin
         report_mismatch($sformatf("digest beat %h with none expected", word));
      end else begin
         want = digest_queue.pop_front();
         if (word !== want.word) begin
            report_mismatch($sformatf("digest word %h, expected %h", word, want.word));
         end
         if (last !== want.last) begin
            report_mismatch($sformatf("tlast %b, expected %b", last, want.last));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         chain = INIT_HASH;
         msg_bytes = '0;
         for (int i = 0; i < 64; i++) begin
            blk[i] = 8'h00;
         end
         digest_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_digest_beat(rsp_tdata, rsp_tlast);
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               append_byte(req_tdata);
            end
            if (req_tlast) begin
               finish_message();
            end
         end
      end
      words_pending = digest_queue.size();
   end

endmodule

@@ tb/sv/tb_sha1_message_digest.sv @@
`timescale 1ns / 100ps
// Testbench top for sha1_message_digest: drives message bytes and end beats with
// random idling on both channels and gives the verdict from sha1_digest_checker.
// Depends on sha1md_pkg, the sha1_message_digest RTL and sha1_digest_checker.
module tb_sha1_message_digest;
   import sha1md_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 300;
   localparam int PHASE_BEATS = 80;
   localparam int PHASE_DIGESTS = 2;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          words_pending;
   int          send_idle;
   int          recv_idle;
   int          beats_sent;
   int          msgs_sent;
   int          quiet_cycles;

   sha1_message_digest DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   sha1_digest_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("Timeout: no beat accepted in %0d cycles", STALL_LIMIT);
         $display("FAIL sha1_message_digest");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input logic [7:0] value, input logic has_byte,
                            input logic end_msg);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid = 1'b0;
         do begin
            @(negedge clock);
         end while ($urandom_range(99) < send_idle);
      end
      req_tvalid = 1'b1;
      req_tdata = value;
      req_tuser = has_byte;
      req_tlast = end_msg;
      do begin
         @(posedge clock);
      end while (!req_tready);
      @(negedge clock);
      if (has_byte || end_msg) begin
         beats_sent++;
      end
      if (end_msg) begin
         msgs_sent++;
      end
   endtask

   task automatic send_message(input int len, input bit byte_on_end);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) begin
            send_beat(8'($urandom), 1'b0, 1'b0);
         end
         send_beat(8'($urandom), 1'b1, byte_on_end && (i == len - 1));
      end
      if (!byte_on_end || len == 0) begin
         send_beat(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   function automatic int pick_length();
      int len;
      case ($urandom_range(9))
         0:       len = 0;
         1, 2, 3: len = $urandom_range(1, 12);
         4:       len = 55;
         5:       len = 56;
         6:       len = 63;
         7:       len = 64;
         8:       len = $urandom_range(13, 40);
         default: len = $urandom_range(65, 100);
      endcase
      return len;
   endfunction

   initial begin
      int phase_beats;
      int phase_msgs;
      int msg_len;
      int budget;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      send_idle = 12;
      recv_idle = 78;
      beats_sent = 0;
      msgs_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty message, then a beat that carries neither a byte nor an end.
      send_beat(8'hFF, 1'b0, 1'b1);
      send_beat(8'h3C, 1'b0, 1'b0);
      // "abc" with the last byte on the end beat.
      send_beat(8'h61, 1'b1, 1'b0);
      send_beat(8'h62, 1'b1, 1'b0);
      send_beat(8'h63, 1'b1, 1'b1);
      // Extreme byte values with an ignored beat inside, ended without a byte.
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'hA5, 1'b0, 1'b0);
      send_beat(8'hAA, 1'b1, 1'b0);
      send_beat(8'h55, 1'b0, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 12;
               recv_idle = 78;
            end
            1: begin
               send_idle = 78;
               recv_idle = 12;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         phase_beats = beats_sent;
         phase_msgs = msgs_sent;
         while (beats_sent - phase_beats < PHASE_BEATS ||
                msgs_sent - phase_msgs < PHASE_DIGESTS) begin
            msg_len = pick_length();
            budget = PHASE_BEATS - (beats_sent - phase_beats) - 1;
            if (budget < 0) begin
               budget = 0;
            end
            if (msg_len > budget) begin
               msg_len = budget;
            end
            send_message(msg_len, $urandom_range(1));
         end
         if (phase == 0) begin
            req_tvalid = 1'b0;
            while (words_pending != 0) begin
               @(negedge clock);
            end
         end
      end

      req_tvalid = 1'b0;
      while (words_pending != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("PASS sha1_message_digest");
      end else begin
         $display("FAIL sha1_message_digest");
      end
      $finish;
   end

endmodule
